>>> rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and field widths shared by the sprite blitter and its channels.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int COORD_W = 9;
    localparam int OFFS_W  = 8;
    localparam int COLOR_W = 8;

    typedef enum logic
    {
        CMD_DRAW = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [OFFS_W-1:0]         offs_t;
    typedef logic [COLOR_W-1:0]        color_t;

endpackage

>>> rtl/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_pixel_if / sbc_result_if
// Valid/ready channels for sprite pixel items and their result items.
// ----------------------------------------------------------------------------
interface sbc_pixel_if;
    import sbc_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   cmd;
    coord_t base_x;
    coord_t base_y;
    offs_t  col_offset;
    offs_t  row_offset;
    color_t pixel_color;
    logic   last;

    modport source
    (
        output valid, cmd, base_x, base_y, col_offset, row_offset, pixel_color, last,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, base_x, base_y, col_offset, row_offset, pixel_color, last,
        output ready
    );
endinterface

interface sbc_result_if;
    import sbc_pkg::*;

    logic   valid;
    logic   ready;
    color_t pixel_value;
    logic   inside_res;
    logic   overlap;
    logic   last_out;

    modport source
    (
        output valid, pixel_value, inside_res, overlap, last_out,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_value, inside_res, overlap, last_out,
        output ready
    );
endinterface

>>> rtl/sprite_blit_with_collision.sv
// ----------------------------------------------------------------------------
// sprite_blit_with_collision
// Clipped sprite pixel writer into a frame store of color indices, with an
// overlap flag per sprite and a read path for save-under and scan-out.
// ----------------------------------------------------------------------------
// Path: an item is registered in the address stage, the old-pixel stage and the
// result register in turn. Throughput: one item per cycle while results are
// taken, set by the single-port frame store, which reads the old pixel and
// writes the new one at the same clock edge. Reset: control state clears at
// once; the frame store is then swept to zero, one entry per cycle, over all
// FRAME_WIDTH*FRAME_HEIGHT entries (12800 by default), and no item is accepted until the sweep ends.
module sprite_blit_with_collision
#(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 80
)
(
    input  logic                clk,
    input  logic                rst_n,
    sbc_pixel_if.sink           pixel,
    sbc_result_if.source        result
);
    import sbc_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = COORD_W + 1;
    localparam int DIM_W  = 11;
    localparam int PROD_W = (POS_W - 1) + DIM_W + 1;

    localparam logic [DIM_W-1:0]  WIDTH_L   = DIM_W'(FRAME_WIDTH);
    localparam logic [DIM_W-1:0]  HEIGHT_L  = DIM_W'(FRAME_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Frame store
    color_t            mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    color_t            mem_wdata;

    // Clearing sweep
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // Handshake and stage movement
    logic in_accept;
    logic out_move;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s1_free;

    // Position and clipping of the incoming item
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    in_inside;
    logic [PROD_W-1:0]       lin_addr;

    // Stage 1: address stage
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              s1_inside_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    color_t            s1_color_reg;
    logic              s1_last_reg;

    // Stage 2: old pixel available
    logic   s2_valid_reg;
    cmd_t   s2_cmd_reg;
    logic   s2_inside_reg;
    color_t s2_color_reg;
    logic   s2_last_reg;
    color_t rd_data_reg;

    // Overlap tracking
    logic   overlap_seen_reg;
    logic   overlap_seen_next;
    color_t old_pixel;
    logic   hit;
    logic   seen_now;

    // Result register
    logic   out_valid_reg;
    color_t out_pixel_reg;
    logic   out_inside_reg;
    logic   out_overlap_reg;
    logic   out_last_reg;

    assign out_move  = !out_valid_reg || result.ready;
    assign s2_move   = s2_valid_reg && out_move;
    assign s2_free   = !s2_valid_reg || out_move;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign pixel.ready = s1_free && !clear_busy_reg;
    assign in_accept = pixel.valid && pixel.ready;

    always_comb
    begin
        pos_x = POS_W'(pixel.base_x) + $signed({2'b00, pixel.col_offset});
        pos_y = POS_W'(pixel.base_y) + $signed({2'b00, pixel.row_offset});
        in_inside = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                    && (DIM_W'(pos_x[POS_W-2:0]) < WIDTH_L)
                    && (DIM_W'(pos_y[POS_W-2:0]) < HEIGHT_L);
        lin_addr = PROD_W'(pos_y[POS_W-2:0]) * PROD_W'(WIDTH_L)
                   + PROD_W'(pos_x[POS_W-2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clear_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = clear_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_move && (s1_cmd_reg == CMD_DRAW) && s1_inside_reg;
            mem_addr  = s1_addr_reg;
            mem_wdata = s1_color_reg;
        end
    end

    // The read takes the value from before this edge's write, so it returns
    // the pixel as it stood before the current item drew over it.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (s1_move)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg    <= pixel.cmd;
            s1_inside_reg <= in_inside;
            s1_addr_reg   <= in_inside ? ADDR_W'(lin_addr) : '0;
            s1_color_reg  <= pixel.pixel_color;
            s1_last_reg   <= pixel.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_inside_reg <= s1_inside_reg;
            s2_color_reg  <= s1_color_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    always_comb
    begin
        old_pixel = s2_inside_reg ? rd_data_reg : '0;
        hit       = (s2_cmd_reg == CMD_DRAW) && s2_inside_reg
                    && (old_pixel != '0) && (s2_color_reg != '0);
        seen_now  = overlap_seen_reg || hit;
        // A draw that closes a sprite reports the flag and then starts fresh.
        if ((s2_cmd_reg == CMD_DRAW) && s2_last_reg)
        begin
            overlap_seen_next = 1'b0;
        end
        else
        begin
            overlap_seen_next = seen_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_seen_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            overlap_seen_reg <= overlap_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_pixel_reg   <= old_pixel;
            out_inside_reg  <= s2_inside_reg;
            out_overlap_reg <= seen_now;
            out_last_reg    <= s2_last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pixel_value = out_pixel_reg;
    assign result.inside_res  = out_inside_reg;
    assign result.overlap     = out_overlap_reg;
    assign result.last_out    = out_last_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing : assert property
    (
        @(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !pixel.ready
    )
    else $error("item accepted during frame store clearing");

    a_read_keeps_overlap : assert property
    (
        @(posedge clk) disable iff (!rst_n)
        (s2_move && (s2_cmd_reg == CMD_READ)) |=> $stable(overlap_seen_reg)
    )
    else $error("read item changed the overlap flag");

    a_last_draw_clears : assert property
    (
        @(posedge clk) disable iff (!rst_n)
        (s2_move && (s2_cmd_reg == CMD_DRAW) && s2_last_reg) |=> !overlap_seen_reg
    )
    else $error("overlap flag not cleared after last sprite pixel");

    a_outside_reads_zero : assert property
    (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_inside_reg) |-> (out_pixel_reg == '0)
    )
    else $error("clipped item returned a nonzero pixel");

    a_no_write_to_pipeline_when_clearing : assert property
    (
        @(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !s1_valid_reg
    )
    else $error("item in flight during frame store clearing");
`endif

endmodule
